// ===== design/cigar_walk_match_runs_macros.svh =====
// assertion macros for the top file, which checks its own logic
`ifndef CIGAR_WALK_MATCH_RUNS_MACROS_SVH
`define CIGAR_WALK_MATCH_RUNS_MACROS_SVH

// same-cycle implication, checked out of reset
`define CWM_ASSERT_NOW(label, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("cigar walk assertion failed");

// next-cycle implication, checked out of reset
`define CWM_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("cigar walk assertion failed");

`endif

// ===== design/cwm_pkg.sv =====
// ---------------------------------------------------------------------------
// cwm_pkg
// types, codes and sizes shared by the cigar walk block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwm_pkg;

  localparam int OP_BITS   = 3;
  localparam int CFG_BITS  = 16;
  localparam int RUN_BITS  = 16;
  localparam int ERR_BITS  = 4;
  localparam int IDX_BITS  = 3;

  localparam int POS_BITS_DEFAULT    = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // operation codes on the input channel
  localparam logic [OP_BITS-1:0] OP_MATCH  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_BITS-1:0] OP_QCLIP  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_TCLIP  = 3'd4;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE   = 4'd0;
  localparam logic [ERR_BITS-1:0] ERR_COORDS = 4'd1;
  localparam logic [ERR_BITS-1:0] ERR_QCLIP  = 4'd2;
  localparam logic [ERR_BITS-1:0] ERR_TCLIP  = 4'd3;
  localparam logic [ERR_BITS-1:0] ERR_MATCH  = 4'd4;
  localparam logic [ERR_BITS-1:0] ERR_INSERT = 4'd5;
  localparam logic [ERR_BITS-1:0] ERR_DELETE = 4'd6;
  localparam logic [ERR_BITS-1:0] ERR_UNSUP  = 4'd7;
  localparam logic [ERR_BITS-1:0] ERR_END    = 4'd8;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_QUERY_LO   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_QUERY_HI   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_QUERY_LEN  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_TARGET_LO  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_TARGET_HI  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_TARGET_LEN = 3'd5;

  typedef enum logic [2:0] {
    CLS_MATCH,
    CLS_INSERT,
    CLS_DELETE,
    CLS_QCLIP,
    CLS_TCLIP,
    CLS_UNSUP
  } cwm_class_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] query_lo;
    logic [CFG_BITS-1:0] query_hi;
    logic [CFG_BITS-1:0] query_len;
    logic [CFG_BITS-1:0] target_lo;
    logic [CFG_BITS-1:0] target_hi;
    logic [CFG_BITS-1:0] target_len;
  } cwm_cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    cwm_class_t          cls;
    logic [CFG_BITS-1:0] op_length;
    logic                first_op;
    logic                last_op;
    logic                coords_bad;
    logic                qclip_ok;
    logic                tclip_ok;
  } cwm_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cwm_q_status_t;

endpackage

// ===== design/cwm_in_if.sv =====
// ---------------------------------------------------------------------------
// cwm_in_if
// channel carrying one parsed cigar operation per item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwm_in_if import cwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  operation;
  logic [CFG_BITS-1:0] op_length;
  logic                first_op;
  logic                last_op;

  modport source (output valid, output operation, output op_length, output first_op,
                  output last_op, input ready);
  modport sink (input valid, input operation, input op_length, input first_op,
                input last_op, output ready);
endinterface

// ===== design/cwm_out_if.sv =====
// ---------------------------------------------------------------------------
// cwm_out_if
// channel carrying one match run result per item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwm_out_if import cwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RUN_BITS-1:0] run_query_start;
  logic [RUN_BITS-1:0] run_target_start;
  logic [RUN_BITS-1:0] run_length;
  logic [ERR_BITS-1:0] error_code;
  logic                walk_done;

  modport source (output valid, output run_query_start, output run_target_start,
                  output run_length, output error_code, output walk_done, input ready);
  modport sink (input valid, input run_query_start, input run_target_start,
                input run_length, input error_code, input walk_done, output ready);
endinterface

// ===== design/cwm_front.sv =====
// ---------------------------------------------------------------------------
// cwm_front
// accepts operations, decodes them and precomputes the window checks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwm_front import cwm_pkg::*; (
  cwm_in_if.sink        ops,
  input  cwm_cfg_t      cfg,
  input  cwm_q_status_t q_status,
  output logic          push,
  output cwm_item_t     item
);

  logic q_coords_bad;
  logic t_coords_bad;

  assign ops.ready = !q_status.full;
  assign push      = ops.valid && !q_status.full;

  assign q_coords_bad = (cfg.query_lo == '0) || (cfg.query_hi == '0) ||
                        (cfg.query_lo > cfg.query_hi) || (cfg.query_hi > cfg.query_len);
  assign t_coords_bad = (cfg.target_lo == '0) || (cfg.target_hi == '0) ||
                        (cfg.target_lo > cfg.target_hi) || (cfg.target_hi > cfg.target_len);

  always_comb begin
    case (ops.operation)
      OP_MATCH:  item.cls = CLS_MATCH;
      OP_INSERT: item.cls = CLS_INSERT;
      OP_DELETE: item.cls = CLS_DELETE;
      OP_QCLIP:  item.cls = CLS_QCLIP;
      OP_TCLIP:  item.cls = CLS_TCLIP;
      default:   item.cls = CLS_UNSUP;
    endcase
    item.op_length  = ops.op_length;
    item.first_op   = ops.first_op;
    item.last_op    = ops.last_op;
    item.coords_bad = q_coords_bad || t_coords_bad;
    // clip length must be lo minus one, never true when lo is zero
    item.qclip_ok   = (cfg.query_lo != '0) && (ops.op_length == cfg.query_lo - 16'd1);
    item.tclip_ok   = (cfg.target_lo != '0) && (ops.op_length == cfg.target_lo - 16'd1);
  end

endmodule

// ===== design/cwm_queue.sv =====
// ---------------------------------------------------------------------------
// cwm_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwm_queue import cwm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cwm_item_t     push_item,
  input  logic          pop,
  output cwm_item_t     pop_item,
  output cwm_q_status_t status
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cwm_item_t           slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_BITS'(DEPTH));
  assign pop_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/cwm_back.sv =====
// ---------------------------------------------------------------------------
// cwm_back
// runs the walk state on each queued item and registers its result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwm_back import cwm_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cwm_cfg_t  cfg,
  input  logic      item_valid,
  input  cwm_item_t item,
  output logic      pop,
  cwm_out_if.source runs
);

  localparam int CMP_BITS = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 1;

  logic [POS_BITS-1:0] query_pos, target_pos;
  logic                started, query_clip_seen, target_clip_seen;
  logic [ERR_BITS-1:0] sticky_error;

  logic [POS_BITS-1:0] query_pos_next, target_pos_next;
  logic                started_next, query_clip_seen_next, target_clip_seen_next;
  logic [ERR_BITS-1:0] sticky_error_next;

  logic [POS_BITS-1:0] q0, t0;
  logic                st0, qc0, tc0;
  logic [ERR_BITS-1:0] err0;
  logic [CMP_BITS-1:0] q0x, t0x, qsum, tsum;
  logic                q_over, t_over;
  logic [RUN_BITS-1:0] rq, rt, rl;

  assign pop = item_valid && (!runs.valid || runs.ready);

  // restart view of the state on a first op, else the held state
  always_comb begin
    if (item.first_op) begin
      q0   = POS_BITS'(cfg.query_lo) - POS_BITS'(1);
      t0   = POS_BITS'(cfg.target_lo) - POS_BITS'(1);
      st0  = 1'b0;
      qc0  = 1'b0;
      tc0  = 1'b0;
      err0 = item.coords_bad ? ERR_COORDS : ERR_NONE;
    end else begin
      q0   = query_pos;
      t0   = target_pos;
      st0  = started;
      qc0  = query_clip_seen;
      tc0  = target_clip_seen;
      err0 = sticky_error;
    end
  end

  assign q0x    = CMP_BITS'(q0);
  assign t0x    = CMP_BITS'(t0);
  assign qsum   = q0x + CMP_BITS'(item.op_length);
  assign tsum   = t0x + CMP_BITS'(item.op_length);
  assign q_over = (item.op_length != '0) && (qsum > CMP_BITS'(cfg.query_len));
  assign t_over = (item.op_length != '0) && (tsum > CMP_BITS'(cfg.target_len));

  always_comb begin
    query_pos_next        = q0;
    target_pos_next       = t0;
    started_next          = st0;
    query_clip_seen_next  = qc0;
    target_clip_seen_next = tc0;
    sticky_error_next     = err0;
    rq = '0;
    rt = '0;
    rl = '0;
    if (err0 == ERR_NONE) begin
      case (item.cls)
        CLS_QCLIP: begin
          if (st0 || qc0 || !item.qclip_ok) sticky_error_next = ERR_QCLIP;
          else query_clip_seen_next = 1'b1;
        end
        CLS_TCLIP: begin
          if (st0 || tc0 || !item.tclip_ok) sticky_error_next = ERR_TCLIP;
          else target_clip_seen_next = 1'b1;
        end
        CLS_MATCH: begin
          started_next = 1'b1;
          if (q_over || t_over) begin
            sticky_error_next = ERR_MATCH;
          end else begin
            rq = q0x[RUN_BITS-1:0];
            rt = t0x[RUN_BITS-1:0];
            rl = item.op_length;
            query_pos_next  = qsum[POS_BITS-1:0];
            target_pos_next = tsum[POS_BITS-1:0];
          end
        end
        CLS_INSERT: begin
          started_next = 1'b1;
          if (q_over) sticky_error_next = ERR_INSERT;
          else query_pos_next = qsum[POS_BITS-1:0];
        end
        CLS_DELETE: begin
          started_next = 1'b1;
          if (t_over) sticky_error_next = ERR_DELETE;
          else target_pos_next = tsum[POS_BITS-1:0];
        end
        default: begin
          started_next      = 1'b1;
          sticky_error_next = ERR_UNSUP;
        end
      endcase
      if ((sticky_error_next == ERR_NONE) && item.last_op &&
          ((CMP_BITS'(query_pos_next) != CMP_BITS'(cfg.query_hi)) ||
           (CMP_BITS'(target_pos_next) != CMP_BITS'(cfg.target_hi)))) begin
        sticky_error_next = ERR_END;
      end
    end
    if (sticky_error_next != ERR_NONE) begin
      rq = '0;
      rt = '0;
      rl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_pos        <= '0;
      target_pos       <= '0;
      started          <= 1'b0;
      query_clip_seen  <= 1'b0;
      target_clip_seen <= 1'b0;
      sticky_error     <= ERR_NONE;
      runs.valid       <= 1'b0;
    end else begin
      if (pop) begin
        query_pos        <= query_pos_next;
        target_pos       <= target_pos_next;
        started          <= started_next;
        query_clip_seen  <= query_clip_seen_next;
        target_clip_seen <= target_clip_seen_next;
        sticky_error     <= sticky_error_next;
        runs.valid       <= 1'b1;
      end else if (runs.ready) begin
        runs.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      runs.run_query_start  <= rq;
      runs.run_target_start <= rt;
      runs.run_length       <= rl;
      runs.error_code       <= sticky_error_next;
      runs.walk_done        <= item.last_op;
    end
  end

endmodule

// ===== design/cigar_walk_match_runs.sv =====
// ---------------------------------------------------------------------------
// cigar_walk_match_runs
// walks parsed cigar operations against configured query and target
// windows and reports each match operation as one aligned run
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake          carries
//  ops      in   valid / ready      operation, op_length, first_op, last_op
//  runs     out  valid / ready      run starts, run_length, error_code, walk_done
//  cfg      in   cfg_write          cfg_index, cfg_data (no read-back)
//
//  one item per cycle sustained while runs ready stays high; each result is registered
//  (its item is written into the queue, then popped into the walk state and the output register)
//  the per-item cost is one add and compare on each running position in the back stage
//  reset loads every window register with one, clears the walk state and empties the queue
//  a stalled result holds the back stage; ops ready drops only once the queue is full
//
`timescale 1ns / 1ps
`include "cigar_walk_match_runs_macros.svh"

module cigar_walk_match_runs import cwm_pkg::*; #(
  parameter int POS_BITS    = POS_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  cwm_in_if.sink              ops,
  cwm_out_if.source           runs,
  input  logic                cfg_write,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  // window registers; the user must change them only while the block is idle, the block does not enforce it
  cwm_cfg_t      cfg;

  // front to queue
  logic          push;
  cwm_item_t     push_item;
  cwm_q_status_t q_status;

  // queue to back
  logic          pop;
  cwm_item_t     pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_lo   <= 16'd1;
      cfg.query_hi   <= 16'd1;
      cfg.query_len  <= 16'd1;
      cfg.target_lo  <= 16'd1;
      cfg.target_hi  <= 16'd1;
      cfg.target_len <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUERY_LO:   cfg.query_lo   <= cfg_data;
        REG_QUERY_HI:   cfg.query_hi   <= cfg_data;
        REG_QUERY_LEN:  cfg.query_len  <= cfg_data;
        REG_TARGET_LO:  cfg.target_lo  <= cfg_data;
        REG_TARGET_HI:  cfg.target_hi  <= cfg_data;
        REG_TARGET_LEN: cfg.target_len <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // front: decode the operation and settle the window checks up front
  cwm_front u_front (
    .ops      (ops),
    .cfg      (cfg),
    .q_status (q_status),
    .push     (push),
    .item     (push_item)
  );

  // short queue so front and back stall independently
  cwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // back: positions, clip flags, sticky error and the result register
  cwm_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (!q_status.empty),
    .item       (pop_item),
    .pop        (pop),
    .runs       (runs)
  );

  // a restart with a bad window reports the coordinate error on its result
  `CWM_ASSERT_NEXT(a_coords_reported, pop && pop_item.first_op && pop_item.coords_bad, runs.error_code == ERR_COORDS)

  // a run of nonzero length never carries an error
  `CWM_ASSERT_NOW(a_run_no_error, runs.valid && (runs.run_length != '0), runs.error_code == ERR_NONE)

  // walk_done follows the last_op flag of the item just carried out
  `CWM_ASSERT_NEXT(a_done_follows, pop, runs.valid && (runs.walk_done == $past(pop_item.last_op)))

endmodule
